/* src/pid_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pid_pkg;

  localparam int DATA_W  = 32;            // Q16.16 signal width
  localparam int COEF_W  = 24;            // widest coefficient (Q8.16)
  localparam int WGT_W   = 17;            // Q1.16 weight, one is 65536
  localparam int XW      = 34;            // multiplicand, room for a difference
  localparam int PROD_W  = XW + COEF_W;   // exact product
  localparam int SAT_W   = 60;            // working width for saturation
  localparam int DIGIT_W_DEF = 4;         // coefficient bits per multiplier cycle

  localparam logic [WGT_W-1:0] Q_ONE = 17'h10000;

  typedef enum logic [1:0] {
    CMD_UPDATE   = 2'd0,
    CMD_OVERRIDE = 2'd1,
    CMD_RESUME   = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_KP   = 3'd0,
    REG_KI   = 3'd1,
    REG_KD   = 3'd2,
    REG_MW   = 3'd3,
    REG_DS   = 3'd4,
    REG_KAW  = 3'd5,
    REG_OMIN = 3'd6,
    REG_OMAX = 3'd7
  } reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ISSUE,
    ST_WAIT,
    ST_DES,
    ST_OUT
  } state_t;

  // multiplier jobs in running order
  typedef enum logic [2:0] {
    OP_PE    = 3'd0,
    OP_PM    = 3'd1,
    OP_MIXE  = 3'd2,
    OP_MIXM  = 3'd3,
    OP_DRAW  = 3'd4,
    OP_DFILT = 3'd5,
    OP_INTEG = 3'd6,
    OP_AW    = 3'd7
  } op_t;

  typedef struct packed {
    logic                     start;
    logic [COEF_W-1:0]        coef;
    logic signed [XW-1:0]     x;
  } mul_req_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    if (&v[SAT_W-1:DATA_W-1] || ~|v[SAT_W-1:DATA_W-1]) begin
      return v[DATA_W-1:0];
    end
    return v[SAT_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  function automatic logic signed [SAT_W-1:0] ext32(input logic signed [DATA_W-1:0] v);
    return {{(SAT_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  // exact product >> 16, floor, saturated
  function automatic logic signed [DATA_W-1:0] scl(input logic signed [PROD_W-1:0] p);
    logic signed [SAT_W-1:0] e;
    e = {{(SAT_W-PROD_W){p[PROD_W-1]}}, p};
    return sat32(e >>> 16);
  endfunction

  function automatic logic signed [DATA_W-1:0] clampv(input logic signed [DATA_W-1:0] v,
                                                      input logic signed [DATA_W-1:0] lo,
                                                      input logic signed [DATA_W-1:0] hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

endpackage
`default_nettype wire

/* src/pid_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// Digit-serial signed x unsigned multiplier, MSB digit of the coefficient first.
module pid_mul #(
  parameter int DIGIT_W = pid_pkg::DIGIT_W_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  pid_pkg::mul_req_t                      req,
  output logic                                   done,
  output logic signed [pid_pkg::PROD_W-1:0]      prod
);

  localparam int STEPS = (pid_pkg::COEF_W + DIGIT_W - 1) / DIGIT_W;
  localparam int PAD_W = STEPS * DIGIT_W;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int PP_W  = pid_pkg::XW + DIGIT_W + 1;

  logic [PAD_W-1:0]                  coef_r;
  logic signed [pid_pkg::XW-1:0]     x_r;
  logic signed [pid_pkg::PROD_W-1:0] acc_r;
  logic [CNT_W-1:0]                  cnt_r;
  logic                              busy_r, done_r;

  logic signed [PP_W-1:0]            pp;
  logic signed [pid_pkg::PROD_W-1:0] acc_nxt;

  always_comb begin
    pp      = x_r * $signed({1'b0, coef_r[PAD_W-1 -: DIGIT_W]});
    acc_nxt = (acc_r <<< DIGIT_W)
            + {{(pid_pkg::PROD_W-PP_W){pp[PP_W-1]}}, pp};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= CNT_W'(cnt_r + 1'b1);
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      coef_r <= PAD_W'(req.coef) << (PAD_W - pid_pkg::COEF_W);
      x_r    <= req.x;
      acc_r  <= '0;
    end else if (busy_r) begin
      coef_r <= coef_r << DIGIT_W;
      acc_r  <= acc_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

/* src/pid_controller_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// PID step, Q16.16 signals, Q8.16 gains, trapezoidal integral with back-calculation
// anti-windup, filtered derivative on measurement, clamped output. One transaction in
// gives one transaction out. All products go through a single digit-serial multiplier
// taking DIGIT_W coefficient bits per cycle. An active update runs eight products in
// sequence; override, resume, unused commands and updates in override use no product
// and go from decode straight to the output state. A new input transaction is taken
// once the previous one has reached the output register, even if that result has not
// yet been taken downstream. Configuration writes (cfg_index is the register number)
// must only be made while the block is idle. No clearing pass after reset.
module pid_controller_step #(
  parameter int DIGIT_W = pid_pkg::DIGIT_W_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [103:0] in_tdata,   // measurement[31:0], target[63:32], reverse[64],
                                   // manual_value[96:65], zero[103:97]
  input  wire  [1:0]   in_tuser,   // cmd[1:0]
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [39:0]  out_tdata,  // drive[31:0], overridden[32], zero[39:33]
  input  wire          cfg_we,
  input  wire  [2:0]   cfg_index,
  input  wire  [31:0]  cfg_wdata
);

  localparam int DW = pid_pkg::DATA_W;
  localparam int CW = pid_pkg::COEF_W;
  localparam int WW = pid_pkg::WGT_W;
  localparam int SAT_MIX = pid_pkg::PROD_W;

  // configuration
  logic [CW-1:0]        kp_r, ki_r, kd_r, kaw_r;
  logic [WW-1:0]        mw_r, ds_r;
  logic signed [DW-1:0] omin_r, omax_r;

  // latched transaction
  pid_pkg::cmd_t        cmd_r;
  logic signed [DW-1:0] meas_r, tgt_r, man_r;
  logic                 rev_r;

  // controller state
  logic signed [DW-1:0] integ_r, pmeas_r, perr_r, pdterm_r, pdrive_r;
  logic                 ovr_r;
  logic signed [DW-1:0] integ_nxt, pmeas_nxt, perr_nxt, pdterm_nxt, pdrive_nxt;
  logic                 ovr_nxt;

  // working values
  logic signed [DW-1:0]              err_r, dmeas_r, pe_r, pm_r, p_r, draw_r, des_r;
  logic signed [DW-1:0]              err_nxt, dmeas_nxt, pe_nxt, pm_nxt, p_nxt;
  logic signed [DW-1:0]              draw_nxt, des_nxt;
  logic signed [pid_pkg::PROD_W-1:0] t1_r, t1_nxt;

  pid_pkg::state_t state_r, state_nxt;
  pid_pkg::op_t    op_r, op_nxt;

  logic                 out_tvalid_r, out_tvalid_nxt;
  logic signed [DW-1:0] out_drive_r, out_drive_nxt;
  logic                 out_ovr_r, out_ovr_nxt;

  pid_pkg::mul_req_t                 mul_req;
  logic                              mul_done;
  logic signed [pid_pkg::PROD_W-1:0] mul_prod;

  logic [WW-1:0] w_sat, a_sat;
  logic          in_acc;

  assign in_tready = (state_r == pid_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign w_sat     = (mw_r > pid_pkg::Q_ONE) ? pid_pkg::Q_ONE : mw_r;
  assign a_sat     = (ds_r > pid_pkg::Q_ONE) ? pid_pkg::Q_ONE : ds_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= '0;
      ki_r   <= '0;
      kd_r   <= '0;
      mw_r   <= '0;
      ds_r   <= pid_pkg::Q_ONE;
      kaw_r  <= '0;
      omin_r <= 32'sh8000_0000;
      omax_r <= 32'sh7FFF_FFFF;
    end else if (cfg_we) begin
      unique case (pid_pkg::reg_t'(cfg_index))
        pid_pkg::REG_KP:   kp_r   <= cfg_wdata[CW-1:0];
        pid_pkg::REG_KI:   ki_r   <= cfg_wdata[CW-1:0];
        pid_pkg::REG_KD:   kd_r   <= cfg_wdata[CW-1:0];
        pid_pkg::REG_MW:   mw_r   <= cfg_wdata[WW-1:0];
        pid_pkg::REG_DS:   ds_r   <= cfg_wdata[WW-1:0];
        pid_pkg::REG_KAW:  kaw_r  <= cfg_wdata[CW-1:0];
        pid_pkg::REG_OMIN: omin_r <= cfg_wdata;
        pid_pkg::REG_OMAX: omax_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input capture, payload only
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= pid_pkg::cmd_t'(in_tuser);
      meas_r <= in_tdata[31:0];
      tgt_r  <= in_tdata[63:32];
      rev_r  <= in_tdata[64];
      man_r  <= in_tdata[96:65];
    end
  end

  // multiplier operand select
  always_comb begin
    logic signed [DW:0]   msum;
    logic signed [DW-1:0] mean;
    msum = {err_r[DW-1], err_r} + {perr_r[DW-1], perr_r};
    mean = msum[DW:1];                           // floor of half
    mul_req.start = (state_r == pid_pkg::ST_ISSUE);
    mul_req.coef  = kp_r;
    mul_req.x     = pid_pkg::XW'(pid_pkg::ext32(err_r));
    case (op_r)
      pid_pkg::OP_PE: begin
        mul_req.coef = kp_r;
        mul_req.x    = pid_pkg::XW'(pid_pkg::ext32(err_r));
      end
      pid_pkg::OP_PM: begin
        mul_req.coef = kp_r;
        mul_req.x    = pid_pkg::XW'(pid_pkg::ext32(dmeas_r));
      end
      pid_pkg::OP_MIXE: begin
        mul_req.coef = CW'(pid_pkg::Q_ONE - w_sat);
        mul_req.x    = pid_pkg::XW'(pid_pkg::ext32(pe_r));
      end
      pid_pkg::OP_MIXM: begin
        mul_req.coef = CW'(w_sat);
        mul_req.x    = pid_pkg::XW'(pid_pkg::ext32(pm_r));
      end
      pid_pkg::OP_DRAW: begin
        mul_req.coef = kd_r;
        mul_req.x    = pid_pkg::XW'(pid_pkg::ext32(dmeas_r));
      end
      pid_pkg::OP_DFILT: begin
        mul_req.coef = CW'(a_sat);
        mul_req.x    = pid_pkg::XW'(pid_pkg::ext32(draw_r) - pid_pkg::ext32(pdterm_r));
      end
      pid_pkg::OP_INTEG: begin
        mul_req.coef = ki_r;
        mul_req.x    = pid_pkg::XW'(pid_pkg::ext32(mean));
      end
      pid_pkg::OP_AW: begin
        mul_req.coef = kaw_r;
        mul_req.x    = pid_pkg::XW'(pid_pkg::ext32(pdrive_r) - pid_pkg::ext32(des_r));
      end
      default: ;
    endcase
  end

  pid_mul #(.DIGIT_W(DIGIT_W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // sequencer
  always_comb begin
    logic signed [DW-1:0]    e, d;
    logic signed [DW-1:0]    sc;
    logic signed [SAT_MIX:0] mix;
    state_nxt      = state_r;
    op_nxt         = op_r;
    integ_nxt      = integ_r;
    pmeas_nxt      = pmeas_r;
    perr_nxt       = perr_r;
    pdterm_nxt     = pdterm_r;
    pdrive_nxt     = pdrive_r;
    ovr_nxt        = ovr_r;
    err_nxt        = err_r;
    dmeas_nxt      = dmeas_r;
    pe_nxt         = pe_r;
    pm_nxt         = pm_r;
    p_nxt          = p_r;
    draw_nxt       = draw_r;
    des_nxt        = des_r;
    t1_nxt         = t1_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_drive_nxt  = out_drive_r;
    out_ovr_nxt    = out_ovr_r;
    e   = pid_pkg::sat32(pid_pkg::ext32(tgt_r) - pid_pkg::ext32(meas_r));
    d   = pid_pkg::sat32(pid_pkg::ext32(meas_r) - pid_pkg::ext32(pmeas_r));
    sc  = pid_pkg::scl(mul_prod);
    mix = {t1_r[pid_pkg::PROD_W-1], t1_r} - {mul_prod[pid_pkg::PROD_W-1], mul_prod};
    unique case (state_r)
      pid_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = pid_pkg::ST_PREP;
      end
      pid_pkg::ST_PREP: begin
        state_nxt = pid_pkg::ST_OUT;
        case (cmd_r)
          pid_pkg::CMD_UPDATE: begin
            pmeas_nxt = meas_r;
            if (!ovr_r) begin
              err_nxt   = rev_r ? pid_pkg::sat32(-pid_pkg::ext32(e)) : e;
              dmeas_nxt = rev_r ? pid_pkg::sat32(-pid_pkg::ext32(d)) : d;
              op_nxt    = pid_pkg::OP_PE;
              state_nxt = pid_pkg::ST_ISSUE;
            end
          end
          pid_pkg::CMD_OVERRIDE: begin
            ovr_nxt    = 1'b1;
            pdrive_nxt = man_r;
          end
          pid_pkg::CMD_RESUME: begin
            if (ovr_r) integ_nxt = pid_pkg::clampv(pdrive_r, omin_r, omax_r);
            ovr_nxt = 1'b0;
          end
          default: ;
        endcase
      end
      pid_pkg::ST_ISSUE: begin
        state_nxt = pid_pkg::ST_WAIT;
      end
      pid_pkg::ST_WAIT: begin
        if (mul_done) begin
          op_nxt    = pid_pkg::op_t'(3'(op_r + 3'd1));
          state_nxt = pid_pkg::ST_ISSUE;
          case (op_r)
            pid_pkg::OP_PE:   pe_nxt = sc;
            pid_pkg::OP_PM:   pm_nxt = sc;
            pid_pkg::OP_MIXE: t1_nxt = mul_prod;
            pid_pkg::OP_MIXM: p_nxt  = pid_pkg::sat32(pid_pkg::SAT_W'(mix >>> 16));
            pid_pkg::OP_DRAW: draw_nxt = sc;
            pid_pkg::OP_DFILT: begin
              pdterm_nxt = pid_pkg::sat32(pid_pkg::ext32(pdterm_r) + pid_pkg::ext32(sc));
              state_nxt  = pid_pkg::ST_DES;
            end
            pid_pkg::OP_INTEG: begin
              integ_nxt = pid_pkg::sat32(pid_pkg::ext32(integ_r) + pid_pkg::ext32(sc));
            end
            pid_pkg::OP_AW: begin
              integ_nxt = pid_pkg::sat32(pid_pkg::ext32(integ_r) + pid_pkg::ext32(sc));
              perr_nxt  = err_r;
              state_nxt = pid_pkg::ST_OUT;
            end
            default: ;
          endcase
        end
      end
      pid_pkg::ST_DES: begin
        des_nxt = pid_pkg::sat32(pid_pkg::ext32(p_r) + pid_pkg::ext32(integ_r)
                                 - pid_pkg::ext32(pdterm_r));
        pdrive_nxt = pid_pkg::clampv(des_nxt, omin_r, omax_r);
        state_nxt  = pid_pkg::ST_ISSUE;
      end
      pid_pkg::ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_drive_nxt  = pdrive_r;
          out_ovr_nxt    = ovr_r;
          state_nxt      = pid_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pid_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pid_pkg::ST_IDLE;
      op_r         <= pid_pkg::OP_PE;
      out_tvalid_r <= 1'b0;
      integ_r      <= '0;
      pmeas_r      <= '0;
      perr_r       <= '0;
      pdterm_r     <= '0;
      pdrive_r     <= '0;
      ovr_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      integ_r      <= integ_nxt;
      pmeas_r      <= pmeas_nxt;
      perr_r       <= perr_nxt;
      pdterm_r     <= pdterm_nxt;
      pdrive_r     <= pdrive_nxt;
      ovr_r        <= ovr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r       <= err_nxt;
    dmeas_r     <= dmeas_nxt;
    pe_r        <= pe_nxt;
    pm_r        <= pm_nxt;
    p_r         <= p_nxt;
    draw_r      <= draw_nxt;
    des_r       <= des_nxt;
    t1_r        <= t1_nxt;
    out_drive_r <= out_drive_nxt;
    out_ovr_r   <= out_ovr_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_ovr_r, out_drive_r};

`ifndef NO_ASSERTIONS
  // multiplier only finishes when the sequencer is waiting for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == pid_pkg::ST_WAIT)
    else $error("multiplier result outside wait state");

  // an accepted transaction always starts with the decode step
  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == pid_pkg::ST_PREP)
    else $error("accepted transaction not decoded");

  // a free output register is loaded from the result state
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pid_pkg::ST_OUT && !out_tvalid_r |=> out_tvalid_r)
    else $error("result not presented");
`endif

endmodule
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;

  localparam int STALL_LIMIT = 5000;  // cycles without any transaction
  localparam int SETTLE      = 128;   // longer than an active update takes
  localparam int HOLD_LEN    = 600;   // long receiver hold-off
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 130;

  typedef struct {
    pid_pkg::cmd_t cmd;
    int            meas;
    int            tgt;
    bit            rev;
    int            man;
  } sample_t;

  // mirror of the controller: its own registers and state, expected outputs in order
  class pid_step_mirror;
    logic [23:0] kp, ki, kd, kaw;
    logic [16:0] mw, ds;
    int          omin, omax;
    int          integ, pmeas, perr, pdterm, pdrive;
    bit          ovr;
    int          drive_q[$];
    bit          ovr_q[$];
    int          errors;
    int          checked;

    function new();
      kp = 0; ki = 0; kd = 0; kaw = 0; mw = 0; ds = 17'h10000;
      omin = int'(32'h8000_0000); omax = int'(32'h7FFF_FFFF);
      integ = 0; pmeas = 0; perr = 0; pdterm = 0; pdrive = 0; ovr = 0;
      errors = 0; checked = 0;
    endfunction

    function int sat(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return int'(32'h8000_0000);
      return int'(v);
    endfunction

    // exact product, floor shift by 16, saturate
    function int coef_mul(longint c, longint x);
      return sat((c * x) >>> 16);
    endfunction

    // inverted limits give omax for values above omax, else omin
    function int limit(int v);
      if (v > omax) return omax;
      if (v < omin) return omin;
      return v;
    endfunction

    function void write_reg(pid_pkg::reg_t idx, logic [31:0] v);
      case (idx)
        pid_pkg::REG_KP:   kp = v[23:0];
        pid_pkg::REG_KI:   ki = v[23:0];
        pid_pkg::REG_KD:   kd = v[23:0];
        pid_pkg::REG_MW:   mw = v[16:0];
        pid_pkg::REG_DS:   ds = v[16:0];
        pid_pkg::REG_KAW:  kaw = v[23:0];
        pid_pkg::REG_OMIN: omin = int'(v);
        pid_pkg::REG_OMAX: omax = int'(v);
        default: ;
      endcase
    endfunction

    function void active_update(int meas, int tgt, bit rev);
      int     err, dm, pe, pm, p, draw, d, des, drv, mean;
      longint w, a, pmix;
      err = sat(longint'(tgt) - meas);
      dm  = sat(longint'(meas) - pmeas);
      if (rev) begin
        err = sat(-longint'(err));
        dm  = sat(-longint'(dm));
      end
      w = (mw > 17'h10000) ? 65536 : longint'(mw);
      a = (ds > 17'h10000) ? 65536 : longint'(ds);
      pe   = coef_mul(longint'(kp), err);
      pm   = coef_mul(longint'(kp), dm);
      pmix = (65536 - w) * pe - w * pm;
      p    = sat(pmix >>> 16);
      draw = coef_mul(longint'(kd), dm);
      d    = sat(longint'(pdterm) + coef_mul(a, longint'(draw) - pdterm));
      des  = sat(longint'(p) + integ - d);
      drv  = limit(des);
      mean = int'((longint'(err) + perr) >>> 1);
      integ = sat(longint'(integ) + coef_mul(longint'(ki), mean));
      integ = sat(longint'(integ) + coef_mul(longint'(kaw), longint'(drv) - des));
      perr   = err;
      pdterm = d;
      pdrive = drv;
    endfunction

    function void take_sample(sample_t s);
      case (s.cmd)
        pid_pkg::CMD_UPDATE: begin
          if (!ovr) active_update(s.meas, s.tgt, s.rev);
          pmeas = s.meas;
        end
        pid_pkg::CMD_OVERRIDE: begin
          ovr    = 1;
          pdrive = s.man;
        end
        pid_pkg::CMD_RESUME: begin
          if (ovr) integ = limit(pdrive);
          ovr = 0;
        end
        default: ;
      endcase
      drive_q.push_back(pdrive);
      ovr_q.push_back(ovr);
    endfunction

    function void check_drive(int d, bit o);
      int exp_d;
      bit exp_o;
      if (drive_q.size() == 0) begin
        $error("unexpected output transaction: drive %0d overridden %0d", d, o);
        errors++;
        return;
      end
      exp_d = drive_q.pop_front();
      exp_o = ovr_q.pop_front();
      checked++;
      if (d !== exp_d) begin
        $error("drive: expected %0d, got %0d", exp_d, d);
        errors++;
      end
      if (o !== exp_o) begin
        $error("overridden: expected %0d, got %0d", exp_o, o);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;   // measurement, target, reverse, manual_value, zero pad
  logic [1:0]   in_tuser;   // cmd
  logic         out_tvalid;
  logic         out_tready;
  logic [39:0]  out_tdata;  // drive, overridden, zero pad
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_wdata;

  pid_step_mirror mirror;
  int             send_idle_pct;   // chance per cycle that the sender sits idle
  int             rx_stall_pct;    // chance per cycle that the receiver stalls
  int             hold_left;       // remaining cycles of a long hold-off
  int             quiet_cycles;
  int             sent;
  int             cur_meas;
  int             cur_tgt;

  pid_controller_step i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Output side: check each transaction, then decide next cycle's tready.
  // Values read here are the ones present before the edge.
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      mirror.check_drive(int'(out_tdata[31:0]), out_tdata[32]);
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog: any transaction on either side restarts the count
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one transaction and hold it until taken; then maybe idle a while.
  task automatic send(sample_t s);
    in_tvalid <= 1'b1;
    in_tuser  <= s.cmd;
    in_tdata  <= {7'b0, s.man, s.rev, s.tgt, s.meas};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    mirror.take_sample(s);
    sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Let every expected result drain, plus a settling margin
  task automatic drain();
    in_tvalid <= 1'b0;
    while (mirror.drive_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Only called while idle; cfg_we lowered once at the end of the burst
  task automatic load_regs(logic [23:0] kp, logic [23:0] ki, logic [23:0] kd,
                           logic [16:0] mw, logic [16:0] ds, logic [23:0] kaw,
                           int lo, int hi);
    logic [31:0] vals[8];
    vals = '{32'(kp), 32'(ki), 32'(kd), 32'(mw), 32'(ds), 32'(kaw), lo, hi};
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= pid_pkg::reg_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      mirror.write_reg(pid_pkg::reg_t'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic sample_t mk(pid_pkg::cmd_t c, int m, int t, bit r, int v);
    sample_t s;
    s.cmd = c; s.meas = m; s.tgt = t; s.rev = r; s.man = v;
    return s;
  endfunction

  // Mostly a plant-like drift around a setpoint, with some full-range samples and override, resume and unused commands
  function automatic sample_t rand_sample();
    sample_t s;
    int      r;
    r = $urandom_range(99);
    s = mk(pid_pkg::CMD_UPDATE, int'($urandom), int'($urandom), 1'($urandom_range(1)),
           int'($urandom));
    if (r < 62) begin
      cur_meas = cur_meas + (int'($urandom_range(16383)) - 8192) * 16;
      if ($urandom_range(15) == 0) cur_tgt = int'($urandom_range(32'h01FF_FFFF)) - 32'h0100_0000;
      s.meas = cur_meas;
      s.tgt  = cur_tgt;
    end else if (r < 74) begin
      // full-range measurement and setpoint
    end else if (r < 84) begin
      s.cmd = pid_pkg::CMD_OVERRIDE;
    end else if (r < 94) begin
      s.cmd = pid_pkg::CMD_RESUME;
    end else begin
      s.cmd = pid_pkg::CMD_NONE;
    end
    return s;
  endfunction

  initial begin
    mirror        = new();
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = pid_pkg::CMD_UPDATE;
    out_tready    = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = pid_pkg::REG_KP;
    cfg_wdata     = '0;
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    hold_left     = 0;
    quiet_cycles  = 0;
    sent          = 0;
    cur_meas      = 0;
    cur_tgt       = 32'h0005_0000;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: moderate gains, output limited to +/-100
    load_regs(24'h010000, 24'h004000, 24'h008000, 17'h08000, 17'h04000, 24'h008000,
              -(100 << 16), 100 << 16);
    send(mk(pid_pkg::CMD_UPDATE, 0, 10 << 16, 1'b0, 0));
    send(mk(pid_pkg::CMD_UPDATE, 2 << 16, 10 << 16, 1'b0, 0));
    // error saturates low
    send(mk(pid_pkg::CMD_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 0));
    // both differences saturate
    send(mk(pid_pkg::CMD_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 0));
    // reverse of saturated
    send(mk(pid_pkg::CMD_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 0));
    send(mk(pid_pkg::CMD_UPDATE, 3 << 16, 1 << 16, 1'b1, -1));
    send(mk(pid_pkg::CMD_OVERRIDE, 0, 0, 1'b0, 32'h7FFF_FFFF));
    send(mk(pid_pkg::CMD_UPDATE, 7 << 16, 9 << 16, 1'b0, 0));     // held output, meas stored
    send(mk(pid_pkg::CMD_NONE, -1, -1, 1'b1, -1));                // unused command
    send(mk(pid_pkg::CMD_RESUME, 0, 0, 1'b0, 0));                 // integral preloaded clamped
    send(mk(pid_pkg::CMD_UPDATE, 7 << 16, 9 << 16, 1'b0, 0));
    send(mk(pid_pkg::CMD_RESUME, 0, 0, 1'b0, 0));                 // resume while active
    send(mk(pid_pkg::CMD_OVERRIDE, 0, 0, 1'b0, 32'h8000_0000));
    send(mk(pid_pkg::CMD_OVERRIDE, 0, 0, 1'b0, -5 << 16));        // override twice
    send(mk(pid_pkg::CMD_RESUME, 0, 0, 1'b0, 0));
    send(mk(pid_pkg::CMD_UPDATE, -3 << 16, 4 << 16, 1'b1, 32'h5555_5555));
    send(mk(pid_pkg::CMD_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'hAAAA_AAAA));
    send(mk(pid_pkg::CMD_UPDATE, 0, 0, 1'b1, 0));
    send(mk(pid_pkg::CMD_NONE, 0, 0, 1'b0, 0));
    send(mk(pid_pkg::CMD_UPDATE, 1, 1000 << 16, 1'b0, 0));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: load_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 17'h10000, 17'h00000, 24'hFFFFFF,
                     int'(32'h8000_0000), 32'h7FFF_FFFF);
        1: load_regs(24'h0, 24'h0, 24'h0, 17'h0, 17'h10000, 24'h0,
                     int'(32'h8000_0000), 32'h7FFF_FFFF);
        2: load_regs(24'h020000, 24'h001000, 24'h010000, 17'h1FFFF, 17'h1FFFF, 24'h004000,
                     1000 << 16, -(1000 << 16));                  // inverted limits, weights above one
        default: begin
          int lo, hi;
          lo = -int'($urandom_range(32'h3FFF_FFFF));
          hi = int'($urandom_range(32'h3FFF_FFFF));
          load_regs(24'($urandom_range(24'h03FFFF)), 24'($urandom_range(24'h00FFFF)),
                    24'($urandom_range(24'h03FFFF)), 17'($urandom_range(17'h10000)),
                    17'($urandom_range(17'h10000)), 24'($urandom_range(24'h01FFFF)), lo, hi);
        end
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin send_idle_pct = 86; rx_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rx_stall_pct = 86; end
        default: begin send_idle_pct = 19; rx_stall_pct = 19; end
      endcase
      if (p == 4) hold_left = HOLD_LEN;   // sender keeps offering, block backs up
      for (int n = 0; n < PHASE_ITEMS; n++) send(rand_sample());
      drain();
    end

    $display("covered %0d input transactions, %0d outputs checked over %0d register settings",
             sent, mirror.checked, PHASES + 1);
    $display("commands, override/resume, reverse, saturation, limit and weight extremes");
    if (mirror.errors == 0 && mirror.drive_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
